FILE: src/slaw_pkg.sv
// ----------------------------------------------------------------------------
// slaw_pkg
// Types and fixed constants shared by the spherical lens address warp.
// ----------------------------------------------------------------------------
package slaw_pkg;

    localparam int LENS_SIZE    = 60;
    localparam int LENS_HALF    = LENS_SIZE / 2;
    localparam int INSIDE_LIMIT = LENS_SIZE * LENS_SIZE / 4;
    localparam int SCREEN_WIDTH = 320;

    localparam int COORD_W    = 6;
    localparam int OFS_W      = COORD_W + 1;
    localparam int SQ_W       = 2 * COORD_W;
    localparam int D2_W       = SQ_W + 1;
    localparam int RAD_W      = 7;
    localparam int RAD2_W     = 2 * RAD_W;
    localparam int DEPTH_W    = 8;
    localparam int MAG_W      = DEPTH_W + COORD_W;
    localparam int LEFT_W     = 9;
    localparam int TOP_W      = 8;
    localparam int ADDR_W     = 16;
    localparam int CFG_DATA_W = 9;

    typedef enum logic [1:0] {
        CFG_LENS_LEFT     = 2'd0,
        CFG_LENS_TOP      = 2'd1,
        CFG_LENS_DEPTH    = 2'd2,
        CFG_SPHERE_RADIUS = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] row;
    } t_in_item;

    typedef struct packed {
        logic              inside_res;
        logic [ADDR_W-1:0] source_address;
        logic [ADDR_W-1:0] target_address;
    } t_out_item;

    typedef struct packed {
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] row;
        logic               in_lens;
        logic               neg_x;
        logic               neg_y;
    } t_side;

    typedef struct packed {
        t_side            side;
        logic [MAG_W-1:0] mag_x;
        logic [MAG_W-1:0] mag_y;
    } t_sq_side;

endpackage

FILE: src/slaw_front.sv
// ----------------------------------------------------------------------------
// slaw_front
// Two stages: center offsets, squares and scaled magnitudes, then the
// inside test and the radicand.
// ----------------------------------------------------------------------------
module slaw_front
    import slaw_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_vld,
    input  t_in_item                  i_item,
    input  logic signed [DEPTH_W-1:0] i_lens_depth,
    input  logic [RAD_W-1:0]          i_sphere_radius,
    output logic                      o_vld,
    output logic [RAD2_W-1:0]         o_diff,
    output t_sq_side                  o_side
);

    logic [OFS_W-1:0]   w_px;
    logic [OFS_W-1:0]   w_py;
    logic [COORD_W-1:0] w_ax;
    logic [COORD_W-1:0] w_ay;
    logic [DEPTH_W-1:0] w_depth_mag;
    logic [D2_W-1:0]    w_d2;
    logic               w_inside;

    logic               r_s1_vld;
    t_side              r_s1_side;
    t_side              n_s1_side;
    logic [SQ_W-1:0]    r_s1_sqx;
    logic [SQ_W-1:0]    n_s1_sqx;
    logic [SQ_W-1:0]    r_s1_sqy;
    logic [SQ_W-1:0]    n_s1_sqy;
    logic [RAD2_W-1:0]  r_s1_rad2;
    logic [RAD2_W-1:0]  n_s1_rad2;
    logic [MAG_W-1:0]   r_s1_magx;
    logic [MAG_W-1:0]   n_s1_magx;
    logic [MAG_W-1:0]   r_s1_magy;
    logic [MAG_W-1:0]   n_s1_magy;

    logic               r_s2_vld;
    t_sq_side           r_s2_side;
    t_sq_side           n_s2_side;
    logic [RAD2_W-1:0]  r_s2_diff;
    logic [RAD2_W-1:0]  n_s2_diff;

    always_comb begin
        w_px = OFS_W'(i_item.column) - OFS_W'(LENS_HALF);
        w_py = OFS_W'(i_item.row) - OFS_W'(LENS_HALF);
        w_ax = w_px[OFS_W-1] ? COORD_W'(-w_px) : COORD_W'(w_px);
        w_ay = w_py[OFS_W-1] ? COORD_W'(-w_py) : COORD_W'(w_py);
        w_depth_mag = i_lens_depth[DEPTH_W-1] ? DEPTH_W'(-i_lens_depth)
                                              : DEPTH_W'(i_lens_depth);
        n_s1_side.column  = i_item.column;
        n_s1_side.row     = i_item.row;
        n_s1_side.in_lens = 1'b0;
        n_s1_side.neg_x   = w_px[OFS_W-1] ^ i_lens_depth[DEPTH_W-1];
        n_s1_side.neg_y   = w_py[OFS_W-1] ^ i_lens_depth[DEPTH_W-1];
        n_s1_sqx  = SQ_W'(w_ax) * SQ_W'(w_ax);
        n_s1_sqy  = SQ_W'(w_ay) * SQ_W'(w_ay);
        n_s1_rad2 = RAD2_W'(i_sphere_radius) * RAD2_W'(i_sphere_radius);
        n_s1_magx = MAG_W'(w_depth_mag) * MAG_W'(w_ax);
        n_s1_magy = MAG_W'(w_depth_mag) * MAG_W'(w_ay);
    end

    always_comb begin
        w_d2     = D2_W'(r_s1_sqx) + D2_W'(r_s1_sqy);
        w_inside = w_d2 < D2_W'(INSIDE_LIMIT);
        n_s2_side.side         = r_s1_side;
        n_s2_side.side.in_lens = w_inside;
        n_s2_side.mag_x        = r_s1_magx;
        n_s2_side.mag_y        = r_s1_magy;
        if (w_inside && (r_s1_rad2 > RAD2_W'(w_d2))) begin
            n_s2_diff = r_s1_rad2 - RAD2_W'(w_d2);
        end else begin
            n_s2_diff = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else if (i_en) begin
            r_s1_vld <= i_vld;
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_side <= n_s1_side;
            r_s1_sqx  <= n_s1_sqx;
            r_s1_sqy  <= n_s1_sqy;
            r_s1_rad2 <= n_s1_rad2;
            r_s1_magx <= n_s1_magx;
            r_s1_magy <= n_s1_magy;
            r_s2_side <= n_s2_side;
            r_s2_diff <= n_s2_diff;
        end
    end

    assign o_vld  = r_s2_vld;
    assign o_diff = r_s2_diff;
    assign o_side = r_s2_side;

endmodule

FILE: src/slaw_sqrt.sv
// ----------------------------------------------------------------------------
// slaw_sqrt
// Pipelined digit-by-digit square root, one result bit per stage.
// Root of diff * 4^FRAC_BITS, i.e. sqrt(diff) with FRAC_BITS fraction bits.
// ----------------------------------------------------------------------------
module slaw_sqrt
    import slaw_pkg::*;
#(
    parameter int FRAC_BITS = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  logic                             i_vld,
    input  logic [RAD2_W-1:0]                i_diff,
    input  t_sq_side                         i_side,
    output logic                             o_vld,
    output logic [RAD_W+FRAC_BITS-1:0]       o_root,
    output t_sq_side                         o_side
);

    localparam int ROOT_W  = RAD_W + FRAC_BITS;
    localparam int RADIC_W = 2 * ROOT_W;
    localparam int REM_W   = ROOT_W + 2;
    localparam int TMP_W   = REM_W + 2;

    logic [ROOT_W-1:0]  r_vld;
    logic [REM_W-1:0]   r_rem     [ROOT_W];
    logic [REM_W-1:0]   n_rem     [ROOT_W];
    logic [ROOT_W-1:0]  r_root    [ROOT_W];
    logic [ROOT_W-1:0]  n_root    [ROOT_W];
    logic [RADIC_W-1:0] r_radic   [ROOT_W];
    logic [RADIC_W-1:0] n_radic   [ROOT_W];
    t_sq_side           r_side    [ROOT_W];

    logic [REM_W-1:0]   w_src_rem   [ROOT_W];
    logic [ROOT_W-1:0]  w_src_root  [ROOT_W];
    logic [RADIC_W-1:0] w_src_radic [ROOT_W];
    t_sq_side           w_src_side  [ROOT_W];
    logic [TMP_W-1:0]   w_tmp       [ROOT_W];
    logic [TMP_W-1:0]   w_trial     [ROOT_W];

    always_comb begin
        w_src_rem[0]   = '0;
        w_src_root[0]  = '0;
        w_src_radic[0] = {i_diff, {(2*FRAC_BITS){1'b0}}};
        w_src_side[0]  = i_side;
        for (int k = 1; k < ROOT_W; k++) begin
            w_src_rem[k]   = r_rem[k-1];
            w_src_root[k]  = r_root[k-1];
            w_src_radic[k] = r_radic[k-1];
            w_src_side[k]  = r_side[k-1];
        end
    end

    always_comb begin
        for (int k = 0; k < ROOT_W; k++) begin
            w_tmp[k]   = {w_src_rem[k], w_src_radic[k][RADIC_W-1 -: 2]};
            w_trial[k] = TMP_W'({w_src_root[k], 2'b01});
            if (w_tmp[k] >= w_trial[k]) begin
                n_rem[k]  = REM_W'(w_tmp[k] - w_trial[k]);
                n_root[k] = {w_src_root[k][ROOT_W-2:0], 1'b1};
            end else begin
                n_rem[k]  = REM_W'(w_tmp[k]);
                n_root[k] = {w_src_root[k][ROOT_W-2:0], 1'b0};
            end
            n_radic[k] = {w_src_radic[k][RADIC_W-3:0], 2'b00};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[ROOT_W-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < ROOT_W; k++) begin
                r_rem[k]   <= n_rem[k];
                r_root[k]  <= n_root[k];
                r_radic[k] <= n_radic[k];
                r_side[k]  <= w_src_side[k];
            end
        end
    end

    assign o_vld  = r_vld[ROOT_W-1];
    assign o_root = r_root[ROOT_W-1];
    assign o_side = r_side[ROOT_W-1];

endmodule

FILE: src/slaw_div.sv
// ----------------------------------------------------------------------------
// slaw_div
// Pipelined restoring divider, two lanes (x and y) sharing one divisor,
// one quotient bit per stage. Quotient = floor(mag * 2^FRAC_BITS / den).
// ----------------------------------------------------------------------------
module slaw_div
    import slaw_pkg::*;
#(
    parameter int FRAC_BITS = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_vld,
    input  logic [RAD_W+FRAC_BITS-1:0]   i_den,
    input  logic [MAG_W-1:0]             i_mag_x,
    input  logic [MAG_W-1:0]             i_mag_y,
    input  t_side                        i_side,
    output logic                         o_vld,
    output logic [MAG_W+FRAC_BITS-1:0]   o_quo_x,
    output logic [MAG_W+FRAC_BITS-1:0]   o_quo_y,
    output t_side                        o_side
);

    localparam int DEN_W = RAD_W + FRAC_BITS;
    localparam int NUM_W = MAG_W + FRAC_BITS;
    localparam int LANES = 2;

    logic [NUM_W-1:0] r_vld;
    logic [DEN_W-1:0] r_den [NUM_W];
    t_side            r_side [NUM_W];
    logic [DEN_W-1:0] r_rem [NUM_W][LANES];
    logic [DEN_W-1:0] n_rem [NUM_W][LANES];
    logic [NUM_W-1:0] r_num [NUM_W][LANES];
    logic [NUM_W-1:0] n_num [NUM_W][LANES];

    logic [DEN_W-1:0] w_src_den  [NUM_W];
    t_side            w_src_side [NUM_W];
    logic [DEN_W-1:0] w_src_rem  [NUM_W][LANES];
    logic [NUM_W-1:0] w_src_num  [NUM_W][LANES];
    logic [DEN_W:0]   w_tmp      [NUM_W][LANES];

    always_comb begin
        w_src_den[0]    = i_den;
        w_src_side[0]   = i_side;
        w_src_rem[0][0] = '0;
        w_src_rem[0][1] = '0;
        w_src_num[0][0] = {i_mag_x, {FRAC_BITS{1'b0}}};
        w_src_num[0][1] = {i_mag_y, {FRAC_BITS{1'b0}}};
        for (int k = 1; k < NUM_W; k++) begin
            w_src_den[k]  = r_den[k-1];
            w_src_side[k] = r_side[k-1];
            for (int l = 0; l < LANES; l++) begin
                w_src_rem[k][l] = r_rem[k-1][l];
                w_src_num[k][l] = r_num[k-1][l];
            end
        end
    end

    always_comb begin
        for (int k = 0; k < NUM_W; k++) begin
            for (int l = 0; l < LANES; l++) begin
                w_tmp[k][l] = {w_src_rem[k][l], w_src_num[k][l][NUM_W-1]};
                if (w_tmp[k][l] >= {1'b0, w_src_den[k]}) begin
                    n_rem[k][l] = DEN_W'(w_tmp[k][l] - {1'b0, w_src_den[k]});
                    n_num[k][l] = {w_src_num[k][l][NUM_W-2:0], 1'b1};
                end else begin
                    n_rem[k][l] = DEN_W'(w_tmp[k][l]);
                    n_num[k][l] = {w_src_num[k][l][NUM_W-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[NUM_W-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < NUM_W; k++) begin
                r_den[k]  <= w_src_den[k];
                r_side[k] <= w_src_side[k];
                for (int l = 0; l < LANES; l++) begin
                    r_rem[k][l] <= n_rem[k][l];
                    r_num[k][l] <= n_num[k][l];
                end
            end
        end
    end

    assign o_vld   = r_vld[NUM_W-1];
    assign o_quo_x = r_num[NUM_W-1][0];
    assign o_quo_y = r_num[NUM_W-1][1];
    assign o_side  = r_side[NUM_W-1];

endmodule

FILE: src/slaw_addr.sv
// ----------------------------------------------------------------------------
// slaw_addr
// Two stages: signed displacement and screen coordinates, then
// row * SCREEN_WIDTH + column for the sample and draw addresses.
// ----------------------------------------------------------------------------
module slaw_addr
    import slaw_pkg::*;
#(
    parameter int FRAC_BITS = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_vld,
    input  logic [MAG_W+FRAC_BITS-1:0]   i_quo_x,
    input  logic [MAG_W+FRAC_BITS-1:0]   i_quo_y,
    input  t_side                        i_side,
    input  logic [LEFT_W-1:0]            i_lens_left,
    input  logic [TOP_W-1:0]             i_lens_top,
    output logic                         o_vld,
    output t_out_item                    o_item
);

    logic [ADDR_W-1:0] w_dx;
    logic [ADDR_W-1:0] w_dy;
    logic [ADDR_W-1:0] w_left;
    logic [ADDR_W-1:0] w_top;

    logic              r_a_vld;
    logic              r_a_inside;
    logic [ADDR_W-1:0] r_a_sx;
    logic [ADDR_W-1:0] n_a_sx;
    logic [ADDR_W-1:0] r_a_sy;
    logic [ADDR_W-1:0] n_a_sy;
    logic [ADDR_W-1:0] r_a_tx;
    logic [ADDR_W-1:0] n_a_tx;
    logic [ADDR_W-1:0] r_a_ty;
    logic [ADDR_W-1:0] n_a_ty;

    logic              r_b_vld;
    t_out_item         r_b_item;
    t_out_item         n_b_item;

    always_comb begin
        w_dx   = i_side.neg_x ? ADDR_W'(-i_quo_x[ADDR_W-1:0]) : i_quo_x[ADDR_W-1:0];
        w_dy   = i_side.neg_y ? ADDR_W'(-i_quo_y[ADDR_W-1:0]) : i_quo_y[ADDR_W-1:0];
        w_left = ADDR_W'(i_lens_left);
        w_top  = ADDR_W'(i_lens_top);
        if (i_side.in_lens) begin
            n_a_sx = w_left + w_dx + ADDR_W'(LENS_HALF);
            n_a_sy = w_top + w_dy + ADDR_W'(LENS_HALF);
        end else begin
            n_a_sx = w_left + ADDR_W'(i_side.column);
            n_a_sy = w_top + ADDR_W'(i_side.row);
        end
        n_a_tx = w_left + ADDR_W'(LENS_SIZE - 1) - ADDR_W'(i_side.column);
        n_a_ty = w_top + ADDR_W'(LENS_SIZE - 1) - ADDR_W'(i_side.row);
    end

    always_comb begin
        n_b_item.inside_res     = r_a_inside;
        n_b_item.source_address = ADDR_W'(r_a_sy * ADDR_W'(SCREEN_WIDTH)) + r_a_sx;
        if (r_a_inside) begin
            n_b_item.target_address = ADDR_W'(r_a_ty * ADDR_W'(SCREEN_WIDTH)) + r_a_tx;
        end else begin
            n_b_item.target_address = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
        end else if (i_en) begin
            r_a_vld <= i_vld;
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_inside <= i_side.in_lens;
            r_a_sx     <= n_a_sx;
            r_a_sy     <= n_a_sy;
            r_a_tx     <= n_a_tx;
            r_a_ty     <= n_a_ty;
            r_b_item   <= n_b_item;
        end
    end

    assign o_vld  = r_b_vld;
    assign o_item = r_b_item;

endmodule

FILE: src/spherical_lens_address_warp.sv
// ----------------------------------------------------------------------------
// spherical_lens_address_warp
// Maps a lens-square pixel to the background address a spherical lens
// samples, its mirrored draw address and an inside-circle flag.
//
// Input channel i_in (column, row) and output channel o_out use valid/ready;
// one transfer each way per item, results in input order.
// Config: i_cfg_we writes i_cfg_data to the register at i_cfg_idx
// (lens_left, lens_top, lens_depth, sphere_radius); write only when idle.
// Throughput: one item per cycle while the receiver does not stall.
// From input transfer to o_out_valid an item passes the front stages, the
// square root pipeline (7 + FRAC_BITS stages), the divider pipeline
// (14 + FRAC_BITS stages), the address stages and the output register.
// Reset clears all valids and loads the register defaults
// (130, 70, -15, 35). When the receiver stalls, the result holds in the
// output register, one more lands in a skid register, then o_in_ready
// drops and the whole pipeline holds.
// ----------------------------------------------------------------------------
module spherical_lens_address_warp
    import slaw_pkg::*;
#(
    parameter int FRAC_BITS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out,
    input  logic                  i_cfg_we,
    input  t_cfg_idx              i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int ROOT_W = RAD_W + FRAC_BITS;
    localparam int QUO_W  = MAG_W + FRAC_BITS;

    logic [LEFT_W-1:0]         r_lens_left;
    logic [TOP_W-1:0]          r_lens_top;
    logic signed [DEPTH_W-1:0] r_lens_depth;
    logic [RAD_W-1:0]          r_sphere_radius;

    logic              w_adv;
    logic              w_fr_vld;
    logic [RAD2_W-1:0] w_fr_diff;
    t_sq_side          w_fr_side;
    logic              w_sq_vld;
    logic [ROOT_W-1:0] w_sq_root;
    t_sq_side          w_sq_side;
    logic [ROOT_W-1:0] w_den;
    logic              w_dv_vld;
    logic [QUO_W-1:0]  w_quo_x;
    logic [QUO_W-1:0]  w_quo_y;
    t_side             w_dv_side;
    logic              w_last_vld;
    t_out_item         w_last_item;
    logic              w_out_free;

    logic              r_out_vld;
    logic              n_out_vld;
    t_out_item         r_out_item;
    t_out_item         n_out_item;
    logic              r_skid_vld;
    logic              n_skid_vld;
    t_out_item         r_skid_item;
    t_out_item         n_skid_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lens_left     <= LEFT_W'(130);
            r_lens_top      <= TOP_W'(70);
            r_lens_depth    <= -8'sd15;
            r_sphere_radius <= RAD_W'(35);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LENS_LEFT:     r_lens_left     <= i_cfg_data[LEFT_W-1:0];
                CFG_LENS_TOP:      r_lens_top      <= i_cfg_data[TOP_W-1:0];
                CFG_LENS_DEPTH:    r_lens_depth    <= i_cfg_data[DEPTH_W-1:0];
                CFG_SPHERE_RADIUS: r_sphere_radius <= i_cfg_data[RAD_W-1:0];
                default:           r_lens_left     <= r_lens_left;
            endcase
        end
    end

    assign w_adv      = !r_skid_vld;
    assign o_in_ready = w_adv;

    slaw_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (w_adv),
        .i_vld           (i_in_valid),
        .i_item          (i_in),
        .i_lens_depth    (r_lens_depth),
        .i_sphere_radius (r_sphere_radius),
        .o_vld           (w_fr_vld),
        .o_diff          (w_fr_diff),
        .o_side          (w_fr_side)
    );

    slaw_sqrt #(
        .FRAC_BITS (FRAC_BITS)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_vld   (w_fr_vld),
        .i_diff  (w_fr_diff),
        .i_side  (w_fr_side),
        .o_vld   (w_sq_vld),
        .o_root  (w_sq_root),
        .o_side  (w_sq_side)
    );

    // a zero root is replaced by one
    assign w_den = (w_sq_root == '0) ? ROOT_W'(1) : w_sq_root;

    slaw_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_vld   (w_sq_vld),
        .i_den   (w_den),
        .i_mag_x (w_sq_side.mag_x),
        .i_mag_y (w_sq_side.mag_y),
        .i_side  (w_sq_side.side),
        .o_vld   (w_dv_vld),
        .o_quo_x (w_quo_x),
        .o_quo_y (w_quo_y),
        .o_side  (w_dv_side)
    );

    slaw_addr #(
        .FRAC_BITS (FRAC_BITS)
    ) u_addr (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_adv),
        .i_vld       (w_dv_vld),
        .i_quo_x     (w_quo_x),
        .i_quo_y     (w_quo_y),
        .i_side      (w_dv_side),
        .i_lens_left (r_lens_left),
        .i_lens_top  (r_lens_top),
        .o_vld       (w_last_vld),
        .o_item      (w_last_item)
    );

    assign w_out_free = !r_out_vld || i_out_ready;

    always_comb begin
        n_out_vld   = r_out_vld;
        n_out_item  = r_out_item;
        n_skid_vld  = r_skid_vld;
        n_skid_item = r_skid_item;
        if (w_out_free) begin
            if (r_skid_vld) begin
                n_out_vld  = 1'b1;
                n_out_item = r_skid_item;
                n_skid_vld = 1'b0;
            end else begin
                n_out_vld  = w_last_vld;
                n_out_item = w_last_item;
            end
        end else if (!r_skid_vld && w_last_vld) begin
            n_skid_vld  = 1'b1;
            n_skid_item = w_last_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            r_out_vld  <= n_out_vld;
            r_skid_vld <= n_skid_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_item  <= n_out_item;
        r_skid_item <= n_skid_item;
    end

    assign o_out_valid = r_out_vld;
    assign o_out       = r_out_item;

endmodule

FILE: src/slaw_chk.sv
// ----------------------------------------------------------------------------
// slaw_chk
// Port-level checks for the spherical lens address warp, bound to the top.
// ----------------------------------------------------------------------------
module slaw_chk
    import slaw_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out
);

    // nothing comes out right after reset
    a_reset_quiet : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("o_out_valid high after reset");

    // outside the circle nothing is drawn
    a_outside_target : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.inside_res |-> o_out.target_address == '0)
        else $error("target address nonzero for pixel outside lens");

    // input backpressure only follows an output stall
    a_ready_drop : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_in_ready) |-> $past(o_out_valid && !i_out_ready))
        else $error("o_in_ready dropped without an output stall");

    // a stalled result holds until transfer
    a_out_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("output changed while stalled");

endmodule

bind spherical_lens_address_warp slaw_chk u_slaw_chk (.*);
